// ===== sv/acf_pkg.sv =====
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants of the allpass chain filter: formats, register
// indexes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int SECTIONS = 256;
    localparam int PAIRS    = SECTIONS / 2;
    localparam int PAIR_W   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int CNT_W    = $clog2(PAIRS + 1);

    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int ST_W       = 24;
    localparam int PROD_W     = COEF_W + ST_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_W     = 15;
    localparam int PAIRS_W    = 8;
    localparam int CMP_W      = (CNT_W > PAIRS_W) ? CNT_W : PAIRS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ST_MAX  = 8388607;
    localparam int ST_MIN  = -8388608;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAIRS = 3'd4;

    localparam logic signed [COEF_W-1:0] RST_ALPHA = 16'sd6554;
    localparam logic signed [COEF_W-1:0] RST_COMPL = 16'sd31457;
    localparam logic signed [COEF_W-1:0] RST_SQ    = 16'sd1311;
    localparam logic signed [COEF_W-1:0] RST_CROSS = -16'sd6291;
    localparam logic [PAIRS_W-1:0]       RST_PAIRS = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X,
        ST_S0,
        ST_S1,
        ST_FIN0,
        ST_FIN1,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_X,
        PH_S0,
        PH_S1,
        PH_FIN0,
        PH_FIN1
    } phase_t;

    typedef struct packed {
        logic              load_in;
        logic              load_out;
        logic              rd_en;
        logic [PAIR_W-1:0] rd_addr;
        logic [PAIR_W-1:0] wr_addr;
        phase_t            phase;
    } ctl_cmd_t;

    typedef struct packed {
        logic [PAIR_W-1:0] last_idx;
    } dp_stat_t;

endpackage

// ===== sv/allpass_chain_filter.sv =====
// ----------------------------------------------------------------------------
// allpass_chain_filter
// Chain of first-order allpass sections worked two at a time.
//
// Input requests arrive on s_valid/s_ready with one Q1.15 sample each; every
// request gives exactly one Q1.15 result on m_valid/m_ready, in order.
// The user must write coefficients and the pair count through cfg_wr_en,
// cfg_index and cfg_wdata only while the block is idle; no logic guards it.
//
// Each section pair is worked in the phases X, S0, S1, FIN0 and FIN1 on
// the two shared multipliers, and one pair's output feeds the next pair.
// A new request is taken only once the previous one has left the chain.
//
// Reset loads the register defaults and marks all state words as zero at
// once through per-row valid bits; no clearing pass is needed.
// A finished result waits in the output register; the next request is
// accepted and worked meanwhile, and it stalls only at its end until the
// output register is free.
// ----------------------------------------------------------------------------
module allpass_chain_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [acf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [acf_pkg::SMP_W-1:0]   s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [acf_pkg::SMP_W-1:0]   m_sample_out
);
    import acf_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    acf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    acf_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== sv/acf_ctrl.sv =====
// ----------------------------------------------------------------------------
// acf_ctrl
// Sequencer of the allpass chain: steps each section pair through its
// multiply, accumulate and write-back phases and owns the result valid.
// ----------------------------------------------------------------------------
module acf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  acf_pkg::dp_stat_t stat,
    output acf_pkg::ctl_cmd_t cmd
);
    import acf_pkg::*;

    ctl_state_t        state_reg, state_next;
    logic [PAIR_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.phase    = PH_NONE;
        cmd.wr_addr  = cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = '0;
                    cnt_next    = '0;
                    state_next  = ST_X;
                end
            end
            ST_X: begin
                cmd.phase  = PH_X;
                state_next = ST_S0;
            end
            ST_S0: begin
                cmd.phase  = PH_S0;
                state_next = ST_S1;
            end
            ST_S1: begin
                cmd.phase  = PH_S1;
                state_next = ST_FIN0;
            end
            ST_FIN0: begin
                cmd.phase  = PH_FIN0;
                state_next = ST_FIN1;
            end
            ST_FIN1: begin
                cmd.phase = PH_FIN1;
                if (cnt_reg == stat.last_idx) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = cnt_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    state_next  = ST_X;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/acf_datapath.sv =====
// ----------------------------------------------------------------------------
// acf_datapath
// Coefficient registers, section state memory, two shared multipliers with
// their accumulators, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module acf_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [acf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic signed [acf_pkg::SMP_W-1:0]   s_sample_in,
    output logic signed [acf_pkg::SMP_W-1:0]   m_sample_out,
    input  acf_pkg::ctl_cmd_t                  cmd,
    output acf_pkg::dp_stat_t                  stat
);
    import acf_pkg::*;

    localparam int R_W = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [R_W-1:0]   R_MAX    = R_W'(ST_MAX);
    localparam logic signed [R_W-1:0]   R_MIN    = R_W'(ST_MIN);
    localparam logic signed [ST_W-1:0]  O_MAX    = ST_W'(OUT_MAX);
    localparam logic signed [ST_W-1:0]  O_MIN    = ST_W'(OUT_MIN);

    function automatic logic signed [ST_W-1:0] rsat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        logic signed [R_W-1:0]   r;
        logic signed [ST_W-1:0]  q;
        t = s + RND_BIAS;
        r = t[ACC_W-1:FRAC_W];
        if (r > R_MAX) begin
            q = R_MAX[ST_W-1:0];
        end else if (r < R_MIN) begin
            q = R_MIN[ST_W-1:0];
        end else begin
            q = r[ST_W-1:0];
        end
        return q;
    endfunction

    // configuration
    logic signed [COEF_W-1:0] alpha_reg, compl_reg, sq_reg, cross_reg;
    logic [PAIRS_W-1:0]       pairs_reg;
    logic [CMP_W-1:0]         pairs_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= RST_ALPHA;
            compl_reg <= RST_COMPL;
            sq_reg    <= RST_SQ;
            cross_reg <= RST_CROSS;
            pairs_reg <= RST_PAIRS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_wdata[COEF_W-1:0];
                REG_COMPL: compl_reg <= cfg_wdata[COEF_W-1:0];
                REG_SQ:    sq_reg    <= cfg_wdata[COEF_W-1:0];
                REG_CROSS: cross_reg <= cfg_wdata[COEF_W-1:0];
                REG_PAIRS: pairs_reg <= cfg_wdata[PAIRS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign pairs_ext = CMP_W'(pairs_reg);

    always_comb begin
        if (pairs_ext == '0) begin
            stat.last_idx = '0;
        end else if (pairs_ext > CMP_W'(PAIRS)) begin
            stat.last_idx = PAIR_W'(PAIRS - 1);
        end else begin
            stat.last_idx = PAIR_W'(pairs_ext - 1'b1);
        end
    end

    // section state memory, one row per pair, valid bits stand in for reset
    logic [2*ST_W-1:0] mem [PAIRS];
    logic [2*ST_W-1:0] mem_rd_reg;
    logic [PAIRS-1:0]  vld_reg;
    logic              rd_vld_reg;
    logic [2*ST_W-1:0] wr_data;

    logic signed [ST_W-1:0] s0, s1;
    logic signed [ST_W-1:0] s1_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.phase == PH_FIN1) begin
                vld_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_vld_reg <= vld_reg[cmd.rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.phase == PH_FIN1) begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            mem_rd_reg <= mem[cmd.rd_addr];
        end
    end

    assign s0 = rd_vld_reg ? mem_rd_reg[ST_W-1:0]      : '0;
    assign s1 = rd_vld_reg ? mem_rd_reg[2*ST_W-1:ST_W] : '0;

    // arithmetic
    logic signed [ST_W-1:0]   x_reg, x_next;
    logic signed [COEF_W-1:0] m1_coef, m2_coef;
    logic signed [ST_W-1:0]   m1_op, m2_op;
    logic signed [PROD_W-1:0] prod1_reg, prod1_next, prod2_reg, prod2_next;
    logic signed [ACC_W-1:0]  acc0_reg, acc0_next, acc1_reg, acc1_next;
    logic signed [ST_W-1:0]   y0_reg, y0_next, s0n_reg, s0n_next;
    logic signed [SMP_W-1:0]  out_reg, out_next;

    always_comb begin
        m1_coef = '0;
        m1_op   = '0;
        m2_coef = '0;
        m2_op   = '0;
        case (cmd.phase)
            PH_X: begin
                m1_coef = sq_reg;
                m1_op   = x_reg;
                m2_coef = alpha_reg;
                m2_op   = x_reg;
            end
            PH_S0: begin
                m1_coef = cross_reg;
                m1_op   = s0;
                m2_coef = compl_reg;
                m2_op   = s0;
            end
            PH_S1: begin
                m1_coef = compl_reg;
                m1_op   = s1;
                m2_coef = alpha_reg;
                m2_op   = s0;
            end
            PH_FIN0: begin
                m1_coef = alpha_reg;
                m1_op   = s1;
            end
            default: begin
            end
        endcase
    end

    assign prod1_next = m1_coef * m1_op;
    assign prod2_next = m2_coef * m2_op;

    assign s1_new  = rsat(ACC_W'(prod1_reg) + (ACC_W'(y0_reg) <<< FRAC_W));
    assign wr_data = {s1_new, s0n_reg};

    always_comb begin
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        y0_next   = y0_reg;
        s0n_next  = s0n_reg;
        x_next    = x_reg;
        out_next  = out_reg;
        if (cmd.load_in) begin
            x_next = ST_W'(s_sample_in);
        end
        case (cmd.phase)
            PH_S0: begin
                acc1_next = ACC_W'(prod1_reg);
                acc0_next = -ACC_W'(prod2_reg);
            end
            PH_S1: begin
                acc1_next = acc1_reg + ACC_W'(prod1_reg);
                acc0_next = acc0_reg + ACC_W'(prod2_reg);
            end
            PH_FIN0: begin
                acc1_next = acc1_reg + ACC_W'(prod1_reg);
                y0_next   = rsat(acc0_reg);
                s0n_next  = rsat(ACC_W'(prod2_reg) + (ACC_W'(x_reg) <<< FRAC_W));
            end
            PH_FIN1: begin
                x_next = rsat(acc1_reg);
            end
            default: begin
            end
        endcase
        if (cmd.load_out) begin
            if (x_reg > O_MAX) begin
                out_next = O_MAX[SMP_W-1:0];
            end else if (x_reg < O_MIN) begin
                out_next = O_MIN[SMP_W-1:0];
            end else begin
                out_next = x_reg[SMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        acc0_reg  <= acc0_next;
        acc1_reg  <= acc1_next;
        y0_reg    <= y0_next;
        s0n_reg   <= s0n_next;
        x_reg     <= x_next;
        out_reg   <= out_next;
    end

    assign m_sample_out = out_reg;

endmodule

// ===== sv/acf_checker.sv =====
// ----------------------------------------------------------------------------
// acf_checker
// Port-level checks of the allpass chain filter: request bookkeeping and
// output hold under stall.
// ----------------------------------------------------------------------------
module acf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [acf_pkg::SMP_W-1:0] m_sample_out
);
    import acf_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 1'b1;
        end else if (!in_acc && out_acc) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("result changed while stalled");

    // one sample in the chain at a time
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("request taken while chain busy");

    // no result without a request behind it
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result without request");

    // at most one in the chain and one waiting at the output
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

endmodule

bind allpass_chain_filter acf_checker u_acf_checker (.*);
